// ----- hdl/fixed_size_pool_allocator_unit_assert.svh -----
// Assertion macros shared by the pool allocator modules.
// A module that uses them must have clk_i and rst_ni in scope.
`ifndef FIXED_SIZE_POOL_ALLOCATOR_UNIT_ASSERT_SVH
`define FIXED_SIZE_POOL_ALLOCATOR_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FSPA_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pool allocator: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define FSPA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pool allocator: next-cycle check failed");

`endif

// ----- hdl/fspa_pkg.sv -----
// Shared types and constants of the fixed-size pool allocator.
// Used by fspa_ctrl, fspa_datapath and the top level; depends on nothing.
package fspa_pkg;

  // Default number of table entries.
  localparam int unsigned POOL_DEPTH_DEFAULT = 256;

  // Field and register widths.
  localparam int unsigned CAP_W      = 9;
  localparam int unsigned SIZE_W     = 13;
  localparam int unsigned ALIGN_W    = 4;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned ITEM_W     = 8;
  localparam int unsigned OFF_W      = 21;
  localparam int unsigned USED_W     = 9;
  localparam int unsigned STRIDE_W   = 13;
  localparam int unsigned AVAL_W     = 9;

  // Stride rules.
  localparam logic [ALIGN_W-1:0]  MIN_ALIGN_LOG2  = 4'd2;
  localparam logic [ALIGN_W-1:0]  MAX_ALIGN_LOG2  = 4'd8;
  localparam logic [SIZE_W-1:0]   MAX_ITEM_SIZE   = 13'd4096;
  localparam logic [STRIDE_W-1:0] BACK_SLOT_BYTES = 13'd4;

  // Register reset values.
  localparam logic [CAP_W-1:0]   CAP_RESET   = 9'd256;
  localparam logic [SIZE_W-1:0]  SIZE_RESET  = 13'd4;
  localparam logic [ALIGN_W-1:0] ALIGN_RESET = 4'd2;

  typedef enum logic {
    MODE_ALLOC = 1'b0,
    MODE_FREE  = 1'b1
  } mode_e;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_FULL     = 2'd1,
    STATUS_BAD_FREE = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POOL_CAPACITY  = 2'd0,
    CFG_ITEM_SIZE      = 2'd1,
    CFG_ALIGNMENT_LOG2 = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    mode_e             mode;
    logic [ITEM_W-1:0] free_index;
  } req_t;

  typedef struct packed {
    logic [ITEM_W-1:0] item_index;
    logic [OFF_W-1:0]  byte_offset;
    status_e           status;
    logic [USED_W-1:0] used_count;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    init_wr;
    logic    capture;
    logic    slot_read;
    logic    alloc_wr;
    logic    swap_wr;
    logic    last_wr;
    logic    fail;
    status_e fail_status;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic init_last;
    logic full;
    logic free_pre_ok;
    logic free_match;
  } sts_t;

endpackage

// ----- hdl/fixed_size_pool_allocator_unit.sv -----
// Top level of the fixed-size pool allocator.
// Depends on fspa_pkg, fspa_ctrl and fspa_datapath.
//
// After reset the block runs a clearing pass over both tables, one entry a
// cycle, and busy_o stays high for the whole pass before the first request
// is taken. A request is taken at a rising edge with start_i high and busy_o
// low. An allocate passes through ST_ALLOC and shows its result on rsp_o with
// done_o high once it leaves that state. A free that passes its checks steps
// through ST_FREE_SLOT, ST_FREE_CHK and ST_FREE_LAST and reads the index
// table twice and writes it twice, each read registered; one that fails
// stops in ST_FREE_SLOT or ST_FREE_CHK. The result is valid for exactly one
// cycle and cannot be held off, and a new request may be taken in that same
// cycle. Configuration writes are always ready and are meant for idle time.

module fixed_size_pool_allocator_unit #(
  parameter int unsigned POOL_DEPTH = fspa_pkg::POOL_DEPTH_DEFAULT
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  fspa_pkg::req_t                  req_i,
  output logic                            done_o,
  output fspa_pkg::rsp_t                  rsp_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [fspa_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [fspa_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  fspa_pkg::cmd_t cmd;
  fspa_pkg::sts_t sts;

  // Register writes are always accepted.
  assign cfg_ready_o = 1'b1;

  // Sequencer.
  fspa_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .mode_i  (req_i.mode),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy_o),
    .done_o  (done_o)
  );

  // Tables, count and results.
  fspa_datapath #(
    .POOL_DEPTH (POOL_DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .rsp_o       (rsp_o)
  );

endmodule

// ----- hdl/fspa_ctrl.sv -----
// Sequencing state machine of the pool allocator.
// Depends on fspa_pkg and the assertion macro header.
`include "fixed_size_pool_allocator_unit_assert.svh"

module fspa_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  fspa_pkg::mode_e mode_i,
  input  fspa_pkg::sts_t  sts_i,
  output fspa_pkg::cmd_t  cmd_o,
  output logic            busy_o,
  output logic            done_o
);

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_ALLOC,
    ST_FREE_SLOT,
    ST_FREE_CHK,
    ST_FREE_LAST
  } state_e;

  state_e state_q, state_d;
  logic   busy_q, busy_d;
  logic   done_q, done_d;

  // Next state and commands for the datapath.
  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    cmd_o   = '0;
    cmd_o.fail_status = fspa_pkg::STATUS_OK;
    case (state_q)
      ST_INIT: begin
        cmd_o.init_wr = 1'b1;
        if (sts_i.init_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.capture = 1'b1;
          state_d = (mode_i == fspa_pkg::MODE_ALLOC) ? ST_ALLOC : ST_FREE_SLOT;
        end
      end
      ST_ALLOC: begin
        if (sts_i.full) begin
          cmd_o.fail        = 1'b1;
          cmd_o.fail_status = fspa_pkg::STATUS_FULL;
        end else begin
          cmd_o.alloc_wr = 1'b1;
        end
        done_d  = 1'b1;
        state_d = ST_IDLE;
      end
      ST_FREE_SLOT: begin
        if (sts_i.free_pre_ok) begin
          cmd_o.slot_read = 1'b1;
          state_d = ST_FREE_CHK;
        end else begin
          cmd_o.fail        = 1'b1;
          cmd_o.fail_status = fspa_pkg::STATUS_BAD_FREE;
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_FREE_CHK: begin
        if (sts_i.free_match) begin
          cmd_o.swap_wr = 1'b1;
          state_d = ST_FREE_LAST;
        end else begin
          cmd_o.fail        = 1'b1;
          cmd_o.fail_status = fspa_pkg::STATUS_BAD_FREE;
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_FREE_LAST: begin
        cmd_o.last_wr = 1'b1;
        done_d  = 1'b1;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    busy_d = (state_d != ST_IDLE);
  end

  // State and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      busy_q  <= 1'b1;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q  <= busy_d;
      done_q  <= done_d;
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;

  `FSPA_ASSERT_NEXT(a_done_single, done_q, !done_q)
  `FSPA_ASSERT_NEXT(a_alloc_finishes, state_q == ST_ALLOC, done_q && (state_q == ST_IDLE))
  `FSPA_ASSERT_SAME(a_busy_matches_state, 1'b1, busy_q == (state_q != ST_IDLE))

endmodule

// ----- hdl/fspa_datapath.sv -----
// Datapath of the pool allocator: index table, back-slot table, count,
// configuration registers and result registers. Depends on fspa_pkg.
`include "fixed_size_pool_allocator_unit_assert.svh"

module fspa_datapath #(
  parameter int unsigned POOL_DEPTH = fspa_pkg::POOL_DEPTH_DEFAULT
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  fspa_pkg::req_t                     req_i,
  input  logic                               cfg_valid_i,
  input  logic [fspa_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [fspa_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  fspa_pkg::cmd_t                     cmd_i,
  output fspa_pkg::sts_t                     sts_o,
  output fspa_pkg::rsp_t                     rsp_o
);

  localparam int unsigned IDX_W = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(POOL_DEPTH + 1);
  localparam int unsigned EXT_W = (CNT_W > fspa_pkg::ITEM_W) ? CNT_W : fspa_pkg::ITEM_W;
  localparam int unsigned CMP_W = (CNT_W > fspa_pkg::CAP_W) ? CNT_W : fspa_pkg::CAP_W;
  localparam int unsigned PROD_W = IDX_W + fspa_pkg::STRIDE_W;

  // Table memories.
  logic [IDX_W-1:0] tbl_mem  [POOL_DEPTH];
  logic [IDX_W-1:0] slot_mem [POOL_DEPTH];

  // Configuration registers.
  logic [fspa_pkg::CAP_W-1:0]   cap_q;
  logic [fspa_pkg::SIZE_W-1:0]  size_q;
  logic [fspa_pkg::ALIGN_W-1:0] align_q;

  // Control state.
  logic [CNT_W-1:0] count_q, count_d;
  logic [IDX_W-1:0] init_q;

  // Request and working registers.
  logic [IDX_W-1:0] idx_q;
  logic             in_range_q;
  logic [IDX_W-1:0] slot_q;
  logic [IDX_W-1:0] last_q;
  logic [IDX_W-1:0] tbl_rd_q;
  logic [IDX_W-1:0] slot_rd_q;

  // Result registers.
  logic [fspa_pkg::ITEM_W-1:0] item_q;
  logic [fspa_pkg::OFF_W-1:0]  offset_q;
  fspa_pkg::status_e           status_q;

  logic [EXT_W-1:0]              idx_ext;
  logic                          idx_in_range;
  logic [CNT_W-1:0]              cnt_m1;
  logic [CMP_W-1:0]              cnt_cmp;
  logic [fspa_pkg::ALIGN_W-1:0]  lg;
  logic [fspa_pkg::SIZE_W-1:0]   sz;
  logic [fspa_pkg::AVAL_W-1:0]   aval;
  logic [fspa_pkg::STRIDE_W-1:0] stride;
  logic [PROD_W-1:0]             prod;

  logic             tbl_we, tbl_re, slot_we, slot_re;
  logic [IDX_W-1:0] tbl_wa, tbl_wd, tbl_ra, slot_wa, slot_wd, slot_ra;

  // Configuration writes; indexes beyond the list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q   <= fspa_pkg::CAP_RESET;
      size_q  <= fspa_pkg::SIZE_RESET;
      align_q <= fspa_pkg::ALIGN_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        fspa_pkg::CFG_POOL_CAPACITY:  cap_q   <= cfg_data_i[fspa_pkg::CAP_W-1:0];
        fspa_pkg::CFG_ITEM_SIZE:      size_q  <= cfg_data_i[fspa_pkg::SIZE_W-1:0];
        fspa_pkg::CFG_ALIGNMENT_LOG2: align_q <= cfg_data_i[fspa_pkg::ALIGN_W-1:0];
        default: ;
      endcase
    end
  end

  // Aligned stride: smallest alignment multiple above item plus back-slot.
  always_comb begin
    if (align_q < fspa_pkg::MIN_ALIGN_LOG2) begin
      lg = fspa_pkg::MIN_ALIGN_LOG2;
    end else if (align_q > fspa_pkg::MAX_ALIGN_LOG2) begin
      lg = fspa_pkg::MAX_ALIGN_LOG2;
    end else begin
      lg = align_q;
    end
    sz     = (size_q > fspa_pkg::MAX_ITEM_SIZE) ? fspa_pkg::MAX_ITEM_SIZE : size_q;
    aval   = fspa_pkg::AVAL_W'(1) << lg;
    stride = (sz + fspa_pkg::STRIDE_W'(aval) + fspa_pkg::BACK_SLOT_BYTES)
             & ~fspa_pkg::STRIDE_W'(aval - fspa_pkg::AVAL_W'(1));
  end

  // Request decode and status to the controller.
  assign idx_ext      = EXT_W'(req_i.free_index);
  assign idx_in_range = idx_ext < EXT_W'(POOL_DEPTH);
  assign cnt_m1       = count_q - CNT_W'(1);
  assign cnt_cmp      = CMP_W'(count_q);
  assign prod         = PROD_W'(tbl_rd_q) * PROD_W'(stride);

  assign sts_o.init_last   = (init_q == IDX_W'(POOL_DEPTH - 1));
  assign sts_o.full        = (cnt_cmp >= CMP_W'(cap_q)) || (cnt_cmp >= CMP_W'(POOL_DEPTH));
  assign sts_o.free_pre_ok = in_range_q && (count_q != '0);
  assign sts_o.free_match  = (CNT_W'(slot_q) < count_q) && (tbl_rd_q == idx_q);

  // Memory port selection.
  always_comb begin
    tbl_re  = cmd_i.capture || cmd_i.slot_read;
    if (cmd_i.slot_read) begin
      tbl_ra = slot_rd_q;
    end else if (req_i.mode == fspa_pkg::MODE_ALLOC) begin
      tbl_ra = count_q[IDX_W-1:0];
    end else begin
      tbl_ra = cnt_m1[IDX_W-1:0];
    end
    tbl_we = cmd_i.init_wr || cmd_i.swap_wr || cmd_i.last_wr;
    if (cmd_i.init_wr) begin
      tbl_wa = init_q;
      tbl_wd = init_q;
    end else if (cmd_i.swap_wr) begin
      tbl_wa = slot_q;
      tbl_wd = last_q;
    end else begin
      tbl_wa = cnt_m1[IDX_W-1:0];
      tbl_wd = idx_q;
    end
    slot_re = cmd_i.capture;
    slot_ra = idx_ext[IDX_W-1:0];
    slot_we = cmd_i.init_wr || cmd_i.alloc_wr || cmd_i.swap_wr;
    if (cmd_i.init_wr) begin
      slot_wa = init_q;
      slot_wd = '0;
    end else if (cmd_i.alloc_wr) begin
      slot_wa = tbl_rd_q;
      slot_wd = count_q[IDX_W-1:0];
    end else begin
      slot_wa = last_q;
      slot_wd = slot_q;
    end
  end

  // Index table memory.
  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      tbl_mem[tbl_wa] <= tbl_wd;
    end
    if (tbl_re) begin
      tbl_rd_q <= tbl_mem[tbl_ra];
    end
  end

  // Back-slot memory.
  always_ff @(posedge clk_i) begin
    if (slot_we) begin
      slot_mem[slot_wa] <= slot_wd;
    end
    if (slot_re) begin
      slot_rd_q <= slot_mem[slot_ra];
    end
  end

  // Allocated count.
  always_comb begin
    count_d = count_q;
    if (cmd_i.alloc_wr) begin
      count_d = count_q + CNT_W'(1);
    end else if (cmd_i.last_wr) begin
      count_d = cnt_m1;
    end
  end

  // Count and clearing-pass pointer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      init_q  <= '0;
    end else begin
      count_q <= count_d;
      if (cmd_i.init_wr) begin
        init_q <= init_q + IDX_W'(1);
      end
    end
  end

  // Working and result registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      idx_q      <= idx_ext[IDX_W-1:0];
      in_range_q <= idx_in_range;
      item_q     <= '0;
      offset_q   <= '0;
      status_q   <= fspa_pkg::STATUS_OK;
    end
    if (cmd_i.slot_read) begin
      slot_q <= slot_rd_q;
      last_q <= tbl_rd_q;
    end
    if (cmd_i.alloc_wr) begin
      item_q   <= fspa_pkg::ITEM_W'(tbl_rd_q);
      offset_q <= fspa_pkg::OFF_W'(prod);
    end
    if (cmd_i.fail) begin
      status_q <= cmd_i.fail_status;
    end
  end

  assign rsp_o.item_index  = item_q;
  assign rsp_o.byte_offset = offset_q;
  assign rsp_o.status      = status_q;
  assign rsp_o.used_count  = fspa_pkg::USED_W'(count_q);

  `FSPA_ASSERT_SAME(a_count_bound, 1'b1, count_q <= CNT_W'(POOL_DEPTH))
  `FSPA_ASSERT_NEXT(a_alloc_incr, cmd_i.alloc_wr, count_q == $past(count_q) + CNT_W'(1))
  `FSPA_ASSERT_NEXT(a_free_decr, cmd_i.last_wr, count_q == $past(count_q) - CNT_W'(1))

endmodule

// ----- tb/tb_fixed_size_pool_allocator_unit.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the fixed-size pool allocator unit.
// Depends on fspa_pkg and fixed_size_pool_allocator_unit; a mirror of the pool
// predicts each response, which is then compared field by field.
module tb_fixed_size_pool_allocator_unit;
  import fspa_pkg::*;

  localparam int unsigned DEPTH = POOL_DEPTH_DEFAULT;

  // Mirror of the pool: permutation table, back-slots, count and registers.
  // It also holds the responses still due from the block, oldest first.
  class pool_mirror;
    logic [ITEM_W-1:0]  item_at [DEPTH];
    logic [ITEM_W-1:0]  slot_of [DEPTH];
    int unsigned        used;
    logic [CAP_W-1:0]   capacity;
    logic [SIZE_W-1:0]  obj_bytes;
    logic [ALIGN_W-1:0] align_log2;
    rsp_t               due_rsp_q [$];
    int unsigned        errors;
    int unsigned        n_alloc, n_full, n_free, n_rejected, n_reg_writes;

    function new();
      for (int i = 0; i < DEPTH; i++) begin
        item_at[i] = ITEM_W'(i);
        slot_of[i] = '0;
      end
      used         = 0;
      capacity     = CAP_RESET;
      obj_bytes    = SIZE_RESET;
      align_log2   = ALIGN_RESET;
      errors       = 0;
      n_alloc      = 0;
      n_full       = 0;
      n_free       = 0;
      n_rejected   = 0;
      n_reg_writes = 0;
    endfunction

    function int unsigned pending();
      return due_rsp_q.size();
    endfunction

    // Picks an item that is currently handed out; only called with used > 0.
    function logic [ITEM_W-1:0] pick_live();
      return item_at[$urandom_range(0, used - 1)];
    endfunction

    function void write_register(cfg_idx_e idx, logic [CFG_DATA_W-1:0] data);
      n_reg_writes++;
      case (idx)
        CFG_POOL_CAPACITY:  capacity   = data[CAP_W-1:0];
        CFG_ITEM_SIZE:      obj_bytes  = data[SIZE_W-1:0];
        CFG_ALIGNMENT_LOG2: align_log2 = data[ALIGN_W-1:0];
        default: ;
      endcase
    endfunction

    // Smallest multiple of the alignment above item plus four-byte back-slot.
    function int unsigned stride();
      int unsigned lg, sz, a;
      lg = align_log2;
      if (lg < MIN_ALIGN_LOG2) lg = MIN_ALIGN_LOG2;
      if (lg > MAX_ALIGN_LOG2) lg = MAX_ALIGN_LOG2;
      sz = (obj_bytes > MAX_ITEM_SIZE) ? MAX_ITEM_SIZE : obj_bytes;
      a  = 1 << lg;
      return (sz + a + BACK_SLOT_BYTES) & ~(a - 1);
    endfunction

    // Applies one accepted request to the mirror and queues its response.
    function void record_request(req_t r);
      rsp_t        want;
      int unsigned limit, item, slot, last_pos, tail_item;
      logic        ok;
      want  = '0;
      limit = (capacity > DEPTH) ? DEPTH : capacity;
      if (r.mode == MODE_ALLOC) begin
        if (used < limit) begin
          item             = item_at[used];
          slot_of[item]    = ITEM_W'(used);
          used++;
          want.item_index  = ITEM_W'(item);
          want.byte_offset = OFF_W'(item * stride());
          want.status      = STATUS_OK;
          n_alloc++;
        end else begin
          want.status = STATUS_FULL;
          n_full++;
        end
      end else begin
        ok   = 1'b0;
        slot = 0;
        if (used > 0) begin
          slot = slot_of[r.free_index];
          ok   = (slot < used) && (item_at[slot] == r.free_index);
        end
        // A valid free swaps the freed item with the last allocated one.
        if (ok) begin
          last_pos           = used - 1;
          tail_item          = item_at[last_pos];
          item_at[slot]      = ITEM_W'(tail_item);
          slot_of[tail_item] = ITEM_W'(slot);
          item_at[last_pos]  = r.free_index;
          used               = last_pos;
          want.status        = STATUS_OK;
          n_free++;
        end else begin
          want.status = STATUS_BAD_FREE;
          n_rejected++;
        end
      end
      want.used_count = USED_W'(used);
      due_rsp_q.push_back(want);
    endfunction

    function void compare(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        errors++;
      end
    endfunction

    function void check_response(rsp_t got);
      rsp_t want;
      if (due_rsp_q.size() == 0) begin
        $error("response transfer with no request outstanding");
        errors++;
        return;
      end
      want = due_rsp_q.pop_front();
      compare("item_index", want.item_index, got.item_index);
      compare("byte_offset", want.byte_offset, got.byte_offset);
      compare("status", want.status, got.status);
      compare("used_count", want.used_count, got.used_count);
    endfunction
  endclass

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  start_i     = 1'b0;
  logic                  busy_o;
  req_t                  req_i       = '0;
  logic                  done_o;
  rsp_t                  rsp_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;

  pool_mirror mirror;
  logic       gaps_on = 1'b1;

  // Phase plan of the random part: capacity written, allocate share, length.
  int unsigned phase_cap       [10] = '{300, 256, 4, 1, 0, 16, 200, 3, 0, 64};
  int unsigned phase_alloc_pct [10] = '{95, 15, 50, 50, 60, 40, 70, 50, 50, 30};
  int unsigned phase_len       [10] = '{320, 300, 150, 120, 200, 150, 250, 120, 150, 150};

  fixed_size_pool_allocator_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .req_i       (req_i),
    .done_o      (done_o),
    .rsp_o       (rsp_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // 10 ns clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Every response transfer is checked at the edge that ends its cycle.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      mirror.check_response(rsp_o);
    end
  end

  function automatic req_t make_req(mode_e m, logic [ITEM_W-1:0] idx);
    req_t r;
    r.mode       = m;
    r.free_index = idx;
    return r;
  endfunction

  // Frees mostly name a live item, so that the swap path is well exercised.
  function automatic req_t random_request(int unsigned alloc_pct);
    req_t r;
    r.free_index = ITEM_W'($urandom_range(0, 255));
    if ($urandom_range(0, 99) < alloc_pct) begin
      r.mode = MODE_ALLOC;
    end else begin
      r.mode = MODE_FREE;
      if (mirror.used > 0 && $urandom_range(0, 99) < 85) r.free_index = mirror.pick_live();
    end
    return r;
  endfunction

  // Presents one request, with an occasional gap first, and waits for the
  // transfer. start_i stays high afterwards so back-to-back requests follow.
  task automatic issue(input req_t r);
    while (gaps_on && $urandom_range(0, 99) < 10) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    start_i <= 1'b1;
    req_i   <= r;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    mirror.record_request(r);
  endtask

  // Stops requesting and waits until every response has come back.
  task automatic settle();
    start_i <= 1'b0;
    while (mirror.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    mirror.write_register(idx, data);
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] cap,
                           input logic [CFG_DATA_W-1:0] size,
                           input logic [CFG_DATA_W-1:0] align);
    write_reg(CFG_POOL_CAPACITY, cap);
    write_reg(CFG_ITEM_SIZE, size);
    write_reg(CFG_ALIGNMENT_LOG2, align);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    logic [CFG_DATA_W-1:0] cap_data, size_data;
    int unsigned           guard;
    mirror = new();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part, reset settings: frees on an empty pool, a swap in the
    // middle, a repeated free and a free of an item never handed out.
    issue(make_req(MODE_FREE, 8'd0));
    issue(make_req(MODE_FREE, 8'd255));
    issue(make_req(MODE_ALLOC, 8'hFF));
    issue(make_req(MODE_ALLOC, 8'd0));
    issue(make_req(MODE_ALLOC, 8'h5A));
    issue(make_req(MODE_FREE, 8'd1));
    issue(make_req(MODE_FREE, 8'd1));
    issue(make_req(MODE_FREE, 8'd200));
    issue(make_req(MODE_ALLOC, 8'hA5));
    issue(make_req(MODE_FREE, 8'd0));

    // Capacity lowered below the count, largest size and alignment.
    settle();
    configure(13'd1, MAX_ITEM_SIZE, 13'd8);
    issue(make_req(MODE_ALLOC, 8'd0));
    issue(make_req(MODE_FREE, mirror.pick_live()));
    issue(make_req(MODE_FREE, mirror.pick_live()));
    issue(make_req(MODE_ALLOC, 8'd0));
    issue(make_req(MODE_ALLOC, 8'd0));

    // Zero capacity, oversized item and alignment above the range.
    settle();
    configure(13'd0, 13'h1FFF, 13'd15);
    issue(make_req(MODE_ALLOC, 8'd0));
    issue(make_req(MODE_FREE, mirror.pick_live()));
    issue(make_req(MODE_FREE, 8'd77));

    // Capacity above the depth, smallest size and alignment below the range.
    settle();
    configure(13'h01FF, 13'd1, 13'd0);
    issue(make_req(MODE_ALLOC, 8'd0));
    issue(make_req(MODE_ALLOC, 8'd0));
    settle();
    configure(13'h1FFF, 13'd4097, 13'd1);
    issue(make_req(MODE_ALLOC, 8'd0));
    issue(make_req(MODE_FREE, mirror.pick_live()));
    settle();
    configure(13'd2, 13'h0AAA, 13'd9);
    issue(make_req(MODE_ALLOC, 8'd0));
    issue(make_req(MODE_FREE, mirror.pick_live()));
    issue(make_req(MODE_ALLOC, 8'd0));

    // Random part: each phase takes new settings while items stay allocated.
    // The first fills the pool up to the depth, the second drains it again.
    for (int p = 0; p < 10; p++) begin
      settle();
      if (p == 4) cap_data = CFG_DATA_W'($urandom_range(0, 8191));
      else if (p == 8) cap_data = CFG_DATA_W'($urandom_range(1, DEPTH));
      else cap_data = CFG_DATA_W'(phase_cap[p]);
      case ($urandom_range(0, 3))
        0:       size_data = 13'd1;
        1:       size_data = MAX_ITEM_SIZE;
        default: size_data = CFG_DATA_W'($urandom_range(0, 8191));
      endcase
      configure(cap_data, size_data, CFG_DATA_W'($urandom_range(0, 8191)));
      // One phase runs with no gaps at all.
      gaps_on = (p != 4);
      for (int k = 0; k < phase_len[p]; k++) begin
        issue(random_request(phase_alloc_pct[p]));
      end
    end

    // Drain, then let the block run quiet before the final check.
    start_i <= 1'b0;
    guard = 0;
    while (mirror.pending() != 0 && guard < 1000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (8) @(posedge clk_i);
    if (mirror.pending() != 0) begin
      $error("%0d responses never arrived", mirror.pending());
      mirror.errors++;
    end

    $display("Covered %0d allocations, %0d refused as full, %0d frees, %0d rejected frees,",
             mirror.n_alloc, mirror.n_full, mirror.n_free, mirror.n_rejected);
    $display("over %0d register writes with capacity, size and alignment at their limits.",
             mirror.n_reg_writes);
    if (mirror.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog well beyond the slowest legal run.
  initial begin
    #3_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/fspa_pkg.sv
hdl/fspa_ctrl.sv
hdl/fspa_datapath.sv
hdl/fixed_size_pool_allocator_unit.sv
tb/tb_fixed_size_pool_allocator_unit.sv
